@@ hdl/ddm_pkg.sv @@
`timescale 1ns / 1ps

package ddm_pkg;

   localparam int SPEED_BITS = 9;
   localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = 9'sd255;
   localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_DEADZONE   = 2'd0;
   localparam logic [1:0] CSR_SLEW_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_MS = 2'd2;

   localparam logic [7:0]  DEADZONE_RESET   = 8'd7;
   localparam logic [8:0]  SLEW_LIMIT_RESET = 9'd15;
   localparam logic [15:0] TIMEOUT_MS_RESET = 16'd1000;

   typedef logic signed [SPEED_BITS-1:0] speed_type;

   typedef struct packed {
      logic [11:0] throttle_raw;
      logic [11:0] steer_raw;
      logic        drive_enable;
      logic        new_packet;
      logic [7:0]  tick_ms;
   } req_payload_type;

   typedef struct packed {
      logic       left_forward;
      logic       left_reverse;
      logic [7:0] left_duty;
      logic       right_forward;
      logic       right_reverse;
      logic [7:0] right_duty;
      logic       link_ok;
   } rsp_payload_type;

   typedef struct packed {
      logic       forward;
      logic       reverse;
      logic [7:0] duty;
   } motor_out_type;

endpackage

@@ hdl/ddm_if.sv @@
`timescale 1ns / 1ps

interface ddm_req_if;
   import ddm_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ddm_rsp_if;
   import ddm_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/ddm_scale.sv @@
`timescale 1ns / 1ps

module ddm_scale #(
   parameter int INPUT_MAX = 4095
) (
   input  logic [11:0]         raw,
   input  logic [7:0]          deadzone,
   output ddm_pkg::speed_type  axis
);
   import ddm_pkg::*;

   // floor(p / INPUT_MAX) as (p * ceil(2^37 / INPUT_MAX)) >> 37, exact for p < 2^21
   localparam int ScaleShift = 37;
   localparam int RecipBits  = 30;
   localparam int ProdBits   = 21 + RecipBits;
   localparam longint unsigned RecipWide =
      ((64'd1 << ScaleShift) + 64'(INPUT_MAX) - 64'd1) / 64'(INPUT_MAX);
   localparam logic [RecipBits-1:0] RecipK = RecipBits'(RecipWide);
   localparam logic [11:0] XCap = (INPUT_MAX >= 4095) ? 12'hFFF : 12'(INPUT_MAX);

   logic [11:0]         x;
   logic [20:0]         prod510;
   logic [ProdBits-1:0] product;
   logic [8:0]          quotient;
   logic signed [9:0]   centered;
   logic [7:0]          mag;

   always_comb begin
      x        = (raw > XCap) ? XCap : raw;
      prod510  = {x, 9'b0} - {8'b0, x, 1'b0};
      product  = ProdBits'(prod510) * ProdBits'(RecipK);
      quotient = product[ScaleShift +: 9];
      centered = $signed({1'b0, quotient}) - 10'sd255;
      mag      = centered[9] ? 8'(-centered) : centered[7:0];
      axis     = (mag < deadzone) ? '0 : centered[SPEED_BITS-1:0];
   end

endmodule

@@ hdl/ddm_ramp.sv @@
`timescale 1ns / 1ps

module ddm_ramp #(
   parameter int DUTY_BITS = 8
) (
   input  ddm_pkg::speed_type     cur,
   input  ddm_pkg::speed_type     target,
   input  logic [8:0]             step,
   input  logic                   run,
   output ddm_pkg::speed_type     speed_next,
   output ddm_pkg::motor_out_type drive
);
   import ddm_pkg::*;

   localparam logic [7:0] DutyCap =
      (DUTY_BITS >= 8) ? 8'hFF : 8'((1 << DUTY_BITS) - 1);

   logic signed [10:0] cur_w;
   logic signed [10:0] tgt_w;
   logic signed [10:0] up;
   logic signed [10:0] down;
   speed_type          ramped;
   logic [7:0]         mag;

   always_comb begin
      cur_w = {{2{cur[8]}}, cur};
      tgt_w = {{2{target[8]}}, target};
      up    = cur_w + $signed({2'b00, step});
      down  = cur_w - $signed({2'b00, step});
      priority if (cur < target) begin
         ramped = (up < tgt_w) ? up[8:0] : target;
      end else if (cur > target) begin
         ramped = (down > tgt_w) ? down[8:0] : target;
      end else begin
         ramped = cur;
      end
      speed_next    = run ? ramped : '0;
      mag           = speed_next[8] ? 8'(-speed_next) : speed_next[7:0];
      drive.forward = !speed_next[8] && (speed_next != '0);
      drive.reverse = speed_next[8];
      drive.duty    = (mag > DutyCap) ? DutyCap : mag;
   end

endmodule

@@ hdl/differential_drive_mixer_ramp_top.sv @@
`timescale 1ns / 1ps
// a request passes the request register, the second stage and the result register
// throughput: one request per cycle unless the receiver stalls; the speed and
// silence update in the second stage loops within that stage, so no gap is needed
// reset: clears pipeline valids, speeds and silence counter, and loads
// deadzone 7, ramp step 15, timeout 1000 ms

module differential_drive_mixer_ramp_top #(
   parameter int INPUT_MAX = 4095,
   parameter int DUTY_BITS = 8
) (
   input  logic          clock,
   input  logic          reset,
   ddm_req_if.sink       req_chan,
   ddm_rsp_if.source     rsp_chan,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);
   import ddm_pkg::*;

   // configuration
   logic [7:0]  deadzone_ff;
   logic [8:0]  slew_limit_ff;
   logic [15:0] timeout_ff;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_take, s2_open, s1_open, s2_move;

   // stage payloads
   req_payload_type s1_data_ff;
   speed_type       s2_thr_ff, s2_str_ff;
   logic            s2_enable_ff, s2_packet_ff;
   logic [7:0]      s2_tick_ff;
   rsp_payload_type out_data_ff, out_data_in;

   // state
   speed_type   left_speed_ff, right_speed_ff;
   logic [15:0] silence_ff, silence_in;

   speed_type          thr_scaled, str_scaled;
   speed_type          left_target, right_target, left_next, right_next;
   logic signed [9:0]  mix_sum, mix_diff;
   logic [16:0]        silence_sum;
   logic               link;
   motor_out_type      left_drive, right_drive;

   function automatic speed_type clamp_speed(input logic signed [9:0] v);
      speed_type r;
      priority if (v > 10'sd255) begin
         r = SPEED_MAX;
      end else if (v < -10'sd255) begin
         r = -SPEED_MAX;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

   assign out_take = !out_valid_ff || rsp_chan.ready;
   assign s2_open  = !s2_valid_ff || out_take;
   assign s1_open  = !s1_valid_ff || s2_open;
   assign s2_move  = s2_valid_ff && out_take;

   assign req_chan.ready   = s1_open;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   assign s1_valid_in  = s1_open ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in  = s2_open ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_take ? s2_valid_ff : out_valid_ff;

   ddm_scale #(.INPUT_MAX(INPUT_MAX)) u_scale_thr (
      .raw      (s1_data_ff.throttle_raw),
      .deadzone (deadzone_ff),
      .axis     (thr_scaled)
   );

   ddm_scale #(.INPUT_MAX(INPUT_MAX)) u_scale_str (
      .raw      (s1_data_ff.steer_raw),
      .deadzone (deadzone_ff),
      .axis     (str_scaled)
   );

   always_comb begin
      silence_sum = {1'b0, silence_ff} + {9'b0, s2_tick_ff};
      if (s2_packet_ff) begin
         silence_in = '0;
      end else begin
         silence_in = silence_sum[16] ? SILENCE_MAX : silence_sum[15:0];
      end
      link         = silence_in <= timeout_ff;
      mix_sum      = {s2_thr_ff[8], s2_thr_ff} + {s2_str_ff[8], s2_str_ff};
      mix_diff     = {s2_thr_ff[8], s2_thr_ff} - {s2_str_ff[8], s2_str_ff};
      left_target  = clamp_speed(mix_sum);
      right_target = clamp_speed(mix_diff);
   end

   ddm_ramp #(.DUTY_BITS(DUTY_BITS)) u_ramp_left (
      .cur        (left_speed_ff),
      .target     (left_target),
      .step       (slew_limit_ff),
      .run        (link && s2_enable_ff),
      .speed_next (left_next),
      .drive      (left_drive)
   );

   ddm_ramp #(.DUTY_BITS(DUTY_BITS)) u_ramp_right (
      .cur        (right_speed_ff),
      .target     (right_target),
      .step       (slew_limit_ff),
      .run        (link && s2_enable_ff),
      .speed_next (right_next),
      .drive      (right_drive)
   );

   always_comb begin
      out_data_in.left_forward  = left_drive.forward;
      out_data_in.left_reverse  = left_drive.reverse;
      out_data_in.left_duty     = left_drive.duty;
      out_data_in.right_forward = right_drive.forward;
      out_data_in.right_reverse = right_drive.reverse;
      out_data_in.right_duty    = right_drive.duty;
      out_data_in.link_ok       = link;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff    <= DEADZONE_RESET;
         slew_limit_ff  <= SLEW_LIMIT_RESET;
         timeout_ff     <= TIMEOUT_MS_RESET;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         left_speed_ff  <= '0;
         right_speed_ff <= '0;
         silence_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEADZONE:   deadzone_ff   <= csr_wdata[7:0];
               CSR_SLEW_LIMIT: slew_limit_ff <= csr_wdata[8:0];
               CSR_TIMEOUT_MS: timeout_ff    <= csr_wdata;
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (s2_move) begin
            left_speed_ff  <= left_next;
            right_speed_ff <= right_next;
            silence_ff     <= silence_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_open) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s2_open) begin
         s2_thr_ff    <= thr_scaled;
         s2_str_ff    <= str_scaled;
         s2_enable_ff <= s1_data_ff.drive_enable;
         s2_packet_ff <= s1_data_ff.new_packet;
         s2_tick_ff   <= s1_data_ff.tick_ms;
      end
      if (out_take) begin
         out_data_ff <= out_data_in;
      end
   end

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !s2_move |=> $stable(left_speed_ff) && $stable(right_speed_ff) && $stable(silence_ff))
      else $error("speed or silence state changed without a transfer");

   a_packet_clears: assert property (@(posedge clock) disable iff (reset)
      s2_move && s2_packet_ff |=> silence_ff == '0)
      else $error("packet did not clear silence counter");

   a_lost_link_stops: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.link_ok |->
         out_data_ff.left_duty == '0 && out_data_ff.right_duty == '0 &&
         !out_data_ff.left_forward && !out_data_ff.left_reverse &&
         !out_data_ff.right_forward && !out_data_ff.right_reverse)
      else $error("motors driven while link is lost");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s2_move |=> out_valid_ff)
      else $error("stage two transfer produced no result");

endmodule

@@ bench/differential_drive_mixer_ramp_top_tb.sv @@
`timescale 1ns / 1ps

module differential_drive_mixer_ramp_top_tb;
   import ddm_pkg::*;

   localparam int INPUT_MAX = 4095;
   localparam int DUTY_MAX = 255;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   class mixer_scoreboard;
      rsp_payload_type expected_cmds[$];
      logic [7:0]  deadzone;
      logic [8:0]  slew_limit;
      logic [15:0] timeout_ms;
      speed_type   left_speed;
      speed_type   right_speed;
      logic [15:0] silence_ms;
      int          errors;

      function new();
         deadzone = DEADZONE_RESET;
         slew_limit = SLEW_LIMIT_RESET;
         timeout_ms = TIMEOUT_MS_RESET;
         left_speed = '0;
         right_speed = '0;
         silence_ms = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_DEADZONE: deadzone = data[7:0];
            CSR_SLEW_LIMIT: slew_limit = data[8:0];
            CSR_TIMEOUT_MS: timeout_ms = data;
            default: ;
         endcase
      endfunction

      function int scale_axis(logic [11:0] raw);
         int x;
         int v;
         int mag;
         x = int'(raw);
         if (x > INPUT_MAX) x = INPUT_MAX;
         v = (x * 510) / INPUT_MAX - 255;
         mag = (v < 0) ? -v : v;
         if (mag < int'(deadzone)) v = 0;
         return v;
      endfunction

      function int clamp_speed(int v);
         if (v > 255) return 255;
         if (v < -255) return -255;
         return v;
      endfunction

      function int slew(int cur, int target);
         int step;
         step = int'(slew_limit);
         if (cur < target) return (cur + step < target) ? cur + step : target;
         if (cur > target) return (cur - step > target) ? cur - step : target;
         return cur;
      endfunction

      function motor_out_type motor_pins(int speed);
         motor_out_type m;
         int mag;
         mag = (speed < 0) ? -speed : speed;
         if (mag > DUTY_MAX) mag = DUTY_MAX;
         m.forward = (speed > 0);
         m.reverse = (speed < 0);
         m.duty = mag[7:0];
         return m;
      endfunction

      function void note_tick(req_payload_type p);
         int sum;
         int thr;
         int str;
         bit link;
         motor_out_type lm;
         motor_out_type rm;
         rsp_payload_type want;
         if (p.new_packet) begin
            silence_ms = '0;
         end else begin
            sum = int'(silence_ms) + int'(p.tick_ms);
            silence_ms = (sum > 65535) ? 16'hFFFF : sum[15:0];
         end
         link = (silence_ms <= timeout_ms);
         if (!link || !p.drive_enable) begin
            left_speed = '0;
            right_speed = '0;
         end else begin
            thr = scale_axis(p.throttle_raw);
            str = scale_axis(p.steer_raw);
            left_speed = speed_type'(slew(int'(left_speed), clamp_speed(thr + str)));
            right_speed = speed_type'(slew(int'(right_speed), clamp_speed(thr - str)));
         end
         lm = motor_pins(int'(left_speed));
         rm = motor_pins(int'(right_speed));
         want.left_forward = lm.forward;
         want.left_reverse = lm.reverse;
         want.left_duty = lm.duty;
         want.right_forward = rm.forward;
         want.right_reverse = rm.reverse;
         want.right_duty = rm.duty;
         want.link_ok = link;
         expected_cmds.push_back(want);
      endfunction

      function void check_motor_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_cmds.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = expected_cmds.pop_front();
         if (got.left_forward !== want.left_forward ||
             got.left_reverse !== want.left_reverse ||
             got.left_duty !== want.left_duty || got.right_forward !== want.right_forward ||
             got.right_reverse !== want.right_reverse || got.right_duty !== want.right_duty ||
             got.link_ok !== want.link_ok) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: expected %b%b %0d %b%b %0d %b, got %b%b %0d %b%b %0d %b",
                        $realtime, want.left_forward, want.left_reverse, want.left_duty,
                        want.right_forward, want.right_reverse, want.right_duty, want.link_ok,
                        got.left_forward, got.left_reverse, got.left_duty,
                        got.right_forward, got.right_reverse, got.right_duty, got.link_ok);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          cycle_count = 0;
   bit          allow_gaps = 1'b1;
   logic [15:0] stall_mask = '0;
   logic [4:0]  stall_phase = '0;
   logic [1:0]  stall_mode = '0;
   mixer_scoreboard mixer_sb;

   ddm_req_if req_if ();
   ddm_rsp_if rsp_if ();

   differential_drive_mixer_ramp_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls on a random mask in two of its four modes; mask and mode are redrawn when the phase wraps
   always @(posedge clock) begin
      if (stall_phase == '0) begin
         stall_mask <= 16'($urandom);
         stall_mode <= 2'($urandom_range(0, 3));
      end
      stall_phase <= stall_phase + 1'b1;
      rsp_if.ready <= (stall_mode < 2) ? 1'b1 : stall_mask[stall_phase[4:1]];
   end

   // request noted before the response so a same-edge pair stays in order
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) mixer_sb.note_tick(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready) mixer_sb.check_motor_result(rsp_if.payload);
   end

   function automatic logic [11:0] random_axis();
      case ($urandom_range(0, 5))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'($urandom_range(1960, 2136));
         3: return $urandom_range(0, 1) ? 12'($urandom_range(4000, 4095))
                                        : 12'($urandom_range(0, 95));
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_request(int pkt_pct, int en_pct);
      req_payload_type p;
      p.throttle_raw = random_axis();
      p.steer_raw = random_axis();
      p.drive_enable = ($urandom_range(0, 99) < en_pct);
      p.new_packet = ($urandom_range(0, 99) < pkt_pct);
      case ($urandom_range(0, 7))
         0: p.tick_ms = 8'hFF;
         1: p.tick_ms = 8'($urandom);
         default: p.tick_ms = 8'($urandom_range(0, 30));
      endcase
      return p;
   endfunction

   function automatic req_payload_type tick_req(int thr, int str, bit en, bit pkt, int ms);
      req_payload_type p;
      p.throttle_raw = thr[11:0];
      p.steer_raw = str[11:0];
      p.drive_enable = en;
      p.new_packet = pkt;
      p.tick_ms = ms[7:0];
      return p;
   endfunction

   task automatic push_request(input req_payload_type p);
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_if.valid <= 1'b0;
      req_if.payload <= random_request(50, 50);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic run_random(input int count, input int pkt_pct, input int en_pct);
      int sent;
      int burst;
      sent = 0;
      allow_gaps = ($urandom_range(0, 3) != 0);
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            push_request(random_request(pkt_pct, en_pct));
            sent++;
         end
         if (allow_gaps && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
   endtask

   // pause until every expected result has come back
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (mixer_sb.expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      mixer_sb.write_reg(idx, data);
   endtask

   task automatic set_config(input logic [15:0] dz, input logic [15:0] rs,
                             input logic [15:0] to);
      write_csr(CSR_DEADZONE, dz);
      write_csr(CSR_SLEW_LIMIT, rs);
      write_csr(CSR_TIMEOUT_MS, to);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_directed();
      push_request(tick_req(2048, 2048, 1, 1, 0));
      push_request(tick_req(4095, 2048, 1, 1, 255));
      push_request(tick_req(4095, 2048, 1, 1, 10));
      push_request(tick_req(4095, 2048, 1, 1, 10));
      push_request(tick_req(0, 2048, 1, 1, 10));
      push_request(tick_req(2048, 4095, 1, 1, 10));
      push_request(tick_req(2048, 0, 1, 1, 10));
      push_request(tick_req(4095, 4095, 1, 1, 10));
      push_request(tick_req(0, 0, 1, 1, 10));
      push_request(tick_req(4095, 0, 1, 1, 10));
      push_request(tick_req(0, 4095, 1, 1, 10));
      push_request(tick_req(4095, 4095, 0, 1, 10));
      push_request(tick_req(2096, 2104, 1, 1, 5));
      push_request(tick_req(1992, 2000, 1, 1, 5));
      // silence builds up until the link drops
      for (int i = 0; i < 5; i++) push_request(tick_req(4095, 2048, 1, 0, 255));
      push_request(tick_req(4095, 2048, 1, 1, 0));
      push_request(tick_req(4095, 2048, 1, 0, 0));
      push_request(tick_req(2048, 2048, 1, 1, 1));
   endtask

   initial begin
      req_payload_type p;
      logic [15:0] dz;
      logic [15:0] rs;
      logic [15:0] to;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_DEADZONE;
      csr_wdata = '0;
      mixer_sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_directed();
      run_random(170, 90, 90);
      wait_idle();

      // silence counter saturates without losing the link
      set_config(16'd0, 16'd510, 16'd65535);
      for (int i = 0; i < 270; i++) begin
         p = random_request(0, 100);
         p.new_packet = 1'b0;
         p.tick_ms = 8'hFF;
         push_request(p);
      end
      run_random(100, 50, 90);
      wait_idle();

      set_config(16'd255, 16'd1, 16'd0);
      run_random(150, 60, 90);
      wait_idle();

      // zero ramp step holds speeds, upper data bits and unused index are dropped
      set_config(16'hA500, 16'd0, 16'd300);
      write_csr(CSR_UNUSED, 16'($urandom));
      csr_write_enable <= 1'b0;
      @(posedge clock);
      run_random(150, 70, 90);
      wait_idle();

      for (int k = 0; k < 4; k++) begin
         dz = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
         rs = 16'($urandom_range(0, 511));
         case ($urandom_range(0, 2))
            0: to = 16'($urandom_range(0, 50));
            1: to = 16'($urandom_range(0, 2000));
            default: to = 16'($urandom);
         endcase
         set_config(dz, rs, to);
         run_random(150, $urandom_range(20, 95), $urandom_range(60, 100));
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mixer_sb.errors == 0 && mixer_sb.expected_cmds.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
